@@ rtl/ffra_pkg.sv @@
// Shared constants, codes and types of the first-fit register run allocator.
// Used by the cell, controller, top level and checker; depends on nothing.
package ffra_pkg;

  localparam int FILE_ENTRIES = 128;
  localparam int IDX_W        = $clog2(FILE_ENTRIES);
  localparam int LEN_W        = 8;
  localparam int REG_W        = 13;
  localparam int BASE_W       = 12;
  localparam int STATUS_W     = 2;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 16;
  // The run counter must hold the file size and compare against any 8-bit length.
  localparam int CNT_W = ($clog2(FILE_ENTRIES + 1) > LEN_W) ? $clog2(FILE_ENTRIES + 1) : LEN_W;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_SCAN,
    CTRL_DONE
  } ctrl_state_t;

  // Scan wave that travels one cell per cycle down the chain.
  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [CNT_W-1:0] count;
    logic             found;
    logic             bad;
    logic [IDX_W-1:0] start;
  } wave_t;

  // Broadcast update of the occupancy bits over an index range.
  typedef struct packed {
    logic             en;
    logic             set;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } commit_t;

endpackage

@@ rtl/ffra_cell.sv @@
// One occupancy cell of the allocator chain: holds one entry's bit and
// advances the scan wave by one position. Depends on ffra_pkg.
module ffra_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ffra_pkg::IDX_W-1:0]  idx,
  input  logic [ffra_pkg::LEN_W-1:0]  run_length,
  input  logic [ffra_pkg::IDX_W-1:0]  range_lo,
  input  logic [ffra_pkg::IDX_W-1:0]  range_hi,
  input  ffra_pkg::commit_t           commit,
  input  ffra_pkg::wave_t             wave_in,
  output ffra_pkg::wave_t             wave_out
);

  logic                          occ;
  ffra_pkg::wave_t               wave_next;
  logic [ffra_pkg::CNT_W-1:0]    count_inc;
  logic [ffra_pkg::CNT_W:0]      start_wide;
  logic                          in_range;

  always_comb begin
    wave_next  = wave_in;
    count_inc  = wave_in.count + 1'b1;
    in_range   = (idx >= range_lo) && (idx <= range_hi);
    start_wide = (ffra_pkg::CNT_W + 1)'(idx) + (ffra_pkg::CNT_W + 1)'(1)
               - (ffra_pkg::CNT_W + 1)'(run_length);
    if (wave_in.kind == ffra_pkg::KIND_ALLOC) begin
      if (!wave_in.found) begin
        if (occ) begin
          wave_next.count = '0;
        end else begin
          wave_next.count = count_inc;
          if (count_inc == ffra_pkg::CNT_W'(run_length)) begin
            wave_next.found = 1'b1;
            wave_next.start = start_wide[ffra_pkg::IDX_W-1:0];
          end
        end
      end
    end else begin
      // A free must find every entry of its run in use.
      if (in_range && !occ) begin
        wave_next.bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else begin
      wave_out <= wave_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (commit.en && (idx >= commit.lo) && (idx <= commit.hi)) begin
      occ <= commit.set;
    end
  end

endmodule

@@ rtl/ffra_ctrl.sv @@
// Sequencer of the allocator: takes items, launches the scan wave, applies
// the update and holds the result register. Depends on ffra_pkg.
module ffra_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ffra_pkg::BASE_W-1:0]     cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ffra_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ffra_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [ffra_pkg::STATUS_W-1:0]   m_tuser,
  output ffra_pkg::wave_t                 wave_first,
  input  ffra_pkg::wave_t                 wave_last,
  output logic [ffra_pkg::LEN_W-1:0]      run_length,
  output logic [ffra_pkg::IDX_W-1:0]      range_lo,
  output logic [ffra_pkg::IDX_W-1:0]      range_hi,
  output ffra_pkg::commit_t               commit
);

  ffra_pkg::ctrl_state_t             state;
  ffra_pkg::ctrl_state_t             state_next;
  logic [ffra_pkg::BASE_W-1:0]       base_address;
  logic                              kind_q;
  logic [ffra_pkg::STATUS_W-1:0]     pend_status;
  logic [ffra_pkg::REG_W-1:0]        pend_grant;

  logic                              accept;
  logic                              scan_end;
  logic                              load_out;
  logic [ffra_pkg::LEN_W-1:0]        in_len;
  logic [ffra_pkg::REG_W-1:0]        in_reg;
  logic [ffra_pkg::REG_W:0]          pos_wide;
  logic [ffra_pkg::REG_W:0]          end_wide;
  logic                              free_bad;
  logic [ffra_pkg::CNT_W:0]          alloc_hi_wide;

  assign in_len   = s_tdata[ffra_pkg::LEN_W-1:0];
  assign in_reg   = s_tdata[ffra_pkg::LEN_W +: ffra_pkg::REG_W];
  assign s_tready = (state == ffra_pkg::CTRL_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign scan_end = (state == ffra_pkg::CTRL_SCAN) && wave_last.valid;
  assign load_out = (state == ffra_pkg::CTRL_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    pos_wide = {1'b0, in_reg} - (ffra_pkg::REG_W + 1)'(base_address);
    end_wide = pos_wide + (ffra_pkg::REG_W + 1)'(in_len);
    free_bad = (in_len == '0)
            || (in_reg < ffra_pkg::REG_W'(base_address))
            || (pos_wide >= (ffra_pkg::REG_W + 1)'(ffra_pkg::FILE_ENTRIES))
            || (end_wide > (ffra_pkg::REG_W + 1)'(ffra_pkg::FILE_ENTRIES));
    alloc_hi_wide = (ffra_pkg::CNT_W + 1)'(wave_last.start)
                  + (ffra_pkg::CNT_W + 1)'(run_length) - (ffra_pkg::CNT_W + 1)'(1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ffra_pkg::CTRL_IDLE: begin
        if (accept) state_next = ffra_pkg::CTRL_SCAN;
      end
      ffra_pkg::CTRL_SCAN: begin
        if (wave_last.valid) state_next = ffra_pkg::CTRL_DONE;
      end
      ffra_pkg::CTRL_DONE: begin
        if (!m_tvalid || m_tready) state_next = ffra_pkg::CTRL_IDLE;
      end
      default: state_next = ffra_pkg::CTRL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffra_pkg::CTRL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg_we) begin
      base_address <= cfg_wdata;
    end
  end

  // The wave enters cell 0 for exactly one cycle per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_first.valid <= 1'b0;
    end else begin
      wave_first.valid <= accept;
      if (accept) begin
        wave_first.kind  <= s_tuser[0];
        wave_first.count <= '0;
        wave_first.found <= 1'b0;
        wave_first.bad   <= (s_tuser[0] == ffra_pkg::KIND_FREE) && free_bad;
        wave_first.start <= '0;
        kind_q           <= s_tuser[0];
        run_length       <= in_len;
        range_lo         <= pos_wide[ffra_pkg::IDX_W-1:0];
        range_hi         <= ffra_pkg::IDX_W'(end_wide - (ffra_pkg::REG_W + 1)'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      commit.en <= 1'b0;
    end else begin
      commit.en <= scan_end && ((kind_q == ffra_pkg::KIND_ALLOC) ? wave_last.found
                                                                  : !wave_last.bad);
      if (scan_end) begin
        if (kind_q == ffra_pkg::KIND_ALLOC) begin
          if (wave_last.found) begin
            commit.set  <= 1'b1;
            commit.lo   <= wave_last.start;
            commit.hi   <= alloc_hi_wide[ffra_pkg::IDX_W-1:0];
            pend_status <= ffra_pkg::ST_DONE;
            pend_grant  <= ffra_pkg::REG_W'(base_address)
                         + ffra_pkg::REG_W'(wave_last.start);
          end else begin
            pend_status <= ffra_pkg::ST_NO_ROOM;
            pend_grant  <= '0;
          end
        end else begin
          pend_grant <= '0;
          if (!wave_last.bad) begin
            commit.set  <= 1'b0;
            commit.lo   <= range_lo;
            commit.hi   <= range_hi;
            pend_status <= ffra_pkg::ST_DONE;
          end else begin
            pend_status <= ffra_pkg::ST_BAD_FREE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
      m_tdata  <= ffra_pkg::OUT_DATA_W'(pend_grant);
      m_tuser  <= pend_status;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

@@ rtl/first_fit_register_run_allocator.sv @@
// Top level of the first-fit register run allocator: controller plus a chain
// of occupancy cells. Depends on ffra_pkg, ffra_cell and ffra_ctrl.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tdata {start_register, run_length}, tuser kind
//  m_*       out        m_tvalid / m_tready  tdata granted_register, tuser status
//  cfg_*     in         cfg_we               cfg_wdata base_address
//
// Each item is carried from acceptance to result by the scan wave, which
// walks the cell chain one entry per cycle. One item is in work at a time;
// a finished result waits in the output register while the next item is
// accepted. Synchronous reset frees every entry at once and clears
// base_address. A stalled output only delays the next scan once a second
// result is ready.
module first_fit_register_run_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ffra_pkg::BASE_W-1:0]     cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // Fields from bit 0: run_length[7:0], start_register[20:8], zero fill.
  input  logic [ffra_pkg::IN_DATA_W-1:0]  s_tdata,
  // Fields from bit 0: kind.
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // Fields from bit 0: granted_register[12:0], zero fill.
  output logic [ffra_pkg::OUT_DATA_W-1:0] m_tdata,
  // Fields from bit 0: status.
  output logic [ffra_pkg::STATUS_W-1:0]   m_tuser
);

  ffra_pkg::wave_t                 wave [ffra_pkg::FILE_ENTRIES+1];
  logic [ffra_pkg::LEN_W-1:0]      run_length;
  logic [ffra_pkg::IDX_W-1:0]      range_lo;
  logic [ffra_pkg::IDX_W-1:0]      range_hi;
  ffra_pkg::commit_t               commit;

  ffra_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .wave_first (wave[0]),
    .wave_last  (wave[ffra_pkg::FILE_ENTRIES]),
    .run_length (run_length),
    .range_lo   (range_lo),
    .range_hi   (range_hi),
    .commit     (commit)
  );

  for (genvar i = 0; i < ffra_pkg::FILE_ENTRIES; i++) begin : g_cell
    ffra_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (ffra_pkg::IDX_W'(i)),
      .run_length (run_length),
      .range_lo   (range_lo),
      .range_hi   (range_hi),
      .commit     (commit),
      .wave_in    (wave[i]),
      .wave_out   (wave[i+1])
    );
  end

endmodule

@@ rtl/ffra_checker.sv @@
// Port-level checks of the allocator, bound to the top level.
// Depends on ffra_pkg and first_fit_register_run_allocator.
module ffra_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ffra_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [ffra_pkg::STATUS_W-1:0]   m_tuser
);

  // A result stays offered until it is taken.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ffra_pkg::ST_DONE) || (m_tuser == ffra_pkg::ST_NO_ROOM)
                 || (m_tuser == ffra_pkg::ST_BAD_FREE))
    else $error("undefined status code");

  // Only a successful allocate carries a register number.
  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ffra_pkg::ST_DONE) |-> (m_tdata == '0))
    else $error("nonzero register on a failed request");

  // An accepted item starts a scan, so the input closes right after it.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted during a scan");

endmodule

bind first_fit_register_run_allocator ffra_checker u_ffra_checker (.*);

@@ verif/tb_first_fit_register_run_allocator.sv @@
// Self-checking testbench for the first-fit register run allocator.
// It runs a directed table and then random allocate/free traffic against its own model.
// Depends on ffra_pkg and the first_fit_register_run_allocator top level.
module tb_first_fit_register_run_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 20000;
  localparam int HOLD_CYCLES   = 1500;
  localparam int PHASE_ITEMS   = 306;
  localparam int N_PHASES      = 5;
  localparam int N_DIRECTED    = 24;

  typedef struct packed {
    logic [ffra_pkg::STATUS_W-1:0] status;
    logic [ffra_pkg::REG_W-1:0]    granted;
  } response_t;

  typedef struct {
    int unsigned first;
    int unsigned len;
  } run_t;

  typedef enum logic {
    ROW_REQUEST,
    ROW_SET_BASE
  } row_op_t;

  // For a base row, addr carries the new base address.
  typedef struct packed {
    row_op_t                       op;
    logic                          knd;
    logic [ffra_pkg::LEN_W-1:0]    len;
    logic [ffra_pkg::REG_W-1:0]    addr;
    logic                          typed;
    logic [ffra_pkg::STATUS_W-1:0] status;
    logic [ffra_pkg::REG_W-1:0]    granted;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ffra_pkg::BASE_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ffra_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ffra_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [ffra_pkg::STATUS_W-1:0] m_tuser;

  logic [ffra_pkg::FILE_ENTRIES-1:0] occupancy = '0;
  logic [ffra_pkg::BASE_W-1:0] base_now = '0;
  int used_entries = 0;
  response_t pending_responses[$];
  run_t live_runs[$];
  int errors = 0;
  int idle_cycles = 0;
  int n_items = 0;
  int n_granted = 0;
  int n_no_room = 0;
  int n_bad_free = 0;
  int n_bases = 1;
  bit no_idle = 1'b0;
  bit hold_pending = 1'b0;

  row_t directed_rows [N_DIRECTED] = '{
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd1,   13'd0,    1'b1, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd0,   13'd0,    1'b1, ffra_pkg::ST_NO_ROOM,  13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd129, 13'd0,    1'b1, ffra_pkg::ST_NO_ROOM,  13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd255, 13'd8191, 1'b1, ffra_pkg::ST_NO_ROOM,  13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd0,   13'd0,    1'b1, ffra_pkg::ST_BAD_FREE, 13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd1,   13'd0,    1'b1, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd128, 13'd0,    1'b1, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd1,   13'd0,    1'b1, ffra_pkg::ST_NO_ROOM,  13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd1,   13'd128,  1'b1, ffra_pkg::ST_BAD_FREE, 13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd255, 13'd8191, 1'b1, ffra_pkg::ST_BAD_FREE, 13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd2,   13'd127,  1'b1, ffra_pkg::ST_BAD_FREE, 13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd128, 13'd0,    1'b1, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd1,   13'd5,    1'b1, ffra_pkg::ST_BAD_FREE, 13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd3,   13'd0,    1'b0, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd5,   13'd0,    1'b0, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd3,   13'd0,    1'b0, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd2,   13'd0,    1'b0, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd4,   13'd0,    1'b0, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd3,   13'd1,    1'b0, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_SET_BASE, ffra_pkg::KIND_ALLOC, 8'd0,   13'd4095, 1'b0, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd1,   13'd0,    1'b1, ffra_pkg::ST_BAD_FREE, 13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd1,   13'd0,    1'b0, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_FREE,  8'd2,   13'd4095, 1'b0, ffra_pkg::ST_DONE,     13'd0},
    '{ROW_REQUEST,  ffra_pkg::KIND_ALLOC, 8'd128, 13'd0,    1'b0, ffra_pkg::ST_DONE,     13'd0}
  };

  first_fit_register_run_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 300);
  endfunction

  // Applies one request to the modeled bitmap and returns the response it causes.
  function automatic response_t predict_response(input logic knd,
                                                 input logic [ffra_pkg::LEN_W-1:0] len,
                                                 input logic [ffra_pkg::REG_W-1:0] addr,
                                                 output int unsigned first);
    response_t resp;
    int unsigned count;
    int unsigned start;
    int unsigned pos;
    logic [31:0] sum;
    bit fits;
    resp.status = ffra_pkg::ST_DONE;
    resp.granted = '0;
    first = 0;
    if (knd == ffra_pkg::KIND_ALLOC) begin
      resp.status = ffra_pkg::ST_NO_ROOM;
      if (len != 0 && len <= ffra_pkg::FILE_ENTRIES) begin
        count = 0;
        start = 0;
        for (int i = 0; i < ffra_pkg::FILE_ENTRIES && resp.status != ffra_pkg::ST_DONE; i++) begin
          if (occupancy[i]) begin
            count = 0;
            start = i + 1;
          end else begin
            count++;
            if (count == len) begin
              resp.status = ffra_pkg::ST_DONE;
              first = start;
            end
          end
        end
        if (resp.status == ffra_pkg::ST_DONE) begin
          for (int i = first; i < first + len; i++) occupancy[i] = 1'b1;
          used_entries += len;
          sum = base_now + first;
          resp.granted = sum[ffra_pkg::REG_W-1:0];
        end
      end
    end else begin
      resp.status = ffra_pkg::ST_BAD_FREE;
      if (len != 0 && addr >= base_now) begin
        pos = addr - base_now;
        if (pos < ffra_pkg::FILE_ENTRIES && len <= ffra_pkg::FILE_ENTRIES - pos) begin
          fits = 1'b1;
          for (int i = pos; i < pos + len; i++) if (!occupancy[i]) fits = 1'b0;
          if (fits) begin
            for (int i = pos; i < pos + len; i++) occupancy[i] = 1'b0;
            used_entries -= len;
            resp.status = ffra_pkg::ST_DONE;
          end
        end
      end
    end
    return resp;
  endfunction

  // Offers one item, waits for its acceptance and records what it must produce.
  task automatic issue_request(input logic knd, input logic [ffra_pkg::LEN_W-1:0] len,
                               input logic [ffra_pkg::REG_W-1:0] addr, input logic typed,
                               input response_t typed_resp);
    int gap;
    int unsigned first;
    response_t resp;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= knd;
    s_tdata <= {3'b000, addr, len};
    do @(posedge clk); while (!s_tready);
    resp = predict_response(knd, len, addr, first);
    pending_responses.push_back(typed ? typed_resp : resp);
    n_items++;
    if (resp.status == ffra_pkg::ST_NO_ROOM) n_no_room++;
    if (resp.status == ffra_pkg::ST_BAD_FREE) n_bad_free++;
    if (knd == ffra_pkg::KIND_ALLOC && resp.status == ffra_pkg::ST_DONE) begin
      n_granted++;
      live_runs.push_back('{first, len});
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_base(input logic [ffra_pkg::BASE_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_now = value;
    n_bases++;
  endtask

  // Mostly well-formed traffic: allocations and frees of runs known to be live,
  // with a share of arbitrary requests mixed in.
  task automatic random_request();
    int r;
    int alloc_pct;
    int k;
    int unsigned part;
    run_t run;
    logic knd;
    logic [ffra_pkg::LEN_W-1:0] len;
    logic [ffra_pkg::REG_W-1:0] addr;
    r = $urandom_range(0, 99);
    alloc_pct = (used_entries > 100) ? 25 : ((used_entries < 40) ? 65 : 45);
    if (r < 12) begin
      knd = 1'($urandom_range(0, 1));
      len = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 6));
      if ($urandom_range(0, 1) == 0) addr = 13'($urandom_range(0, 8191));
      else addr = 13'(base_now + $urandom_range(0, 135) - 4);
    end else if (r < 12 + alloc_pct || live_runs.size() == 0) begin
      knd = ffra_pkg::KIND_ALLOC;
      len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(13, 128)) : 8'($urandom_range(1, 12));
      addr = 13'($urandom_range(0, 8191));
    end else begin
      k = $urandom_range(0, live_runs.size() - 1);
      run = live_runs[k];
      live_runs.delete(k);
      // Sometimes free only the front of a run and keep the rest live.
      if (run.len > 1 && $urandom_range(0, 3) == 0) begin
        part = $urandom_range(1, run.len - 1);
        live_runs.push_back('{run.first + part, run.len - part});
        run.len = part;
      end
      knd = ffra_pkg::KIND_FREE;
      len = 8'(run.len);
      addr = 13'(base_now + run.first);
    end
    issue_request(knd, len, addr, 1'b0, '0);
  endtask

  // Result side: random stalls, one long hold-off on request, and the checks.
  initial begin
    int stall;
    bit hold_taken;
    response_t want;
    stall = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (pending_responses.size() == 0) begin
          $error("unexpected result: status %0d, granted_register %0d",
                 m_tuser, m_tdata[ffra_pkg::REG_W-1:0]);
          errors++;
        end else begin
          want = pending_responses.pop_front();
          if (m_tuser !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
            errors++;
          end
          if (m_tdata[ffra_pkg::REG_W-1:0] !== want.granted) begin
            $error("granted_register mismatch: expected %0d, got %0d",
                   want.granted, m_tdata[ffra_pkg::REG_W-1:0]);
            errors++;
          end
        end
        stall = pick_gap();
      end else if (stall == 0 && !no_idle && $urandom_range(0, 49) == 0) begin
        stall = $urandom_range(1, 8);
      end
      if (hold_pending && !hold_taken) begin
        hold_taken = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    response_t typed_resp;
    logic [ffra_pkg::BASE_W-1:0] bases [N_PHASES];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].op == ROW_SET_BASE) begin
        set_base(directed_rows[i].addr[ffra_pkg::BASE_W-1:0]);
      end else begin
        typed_resp.status = directed_rows[i].status;
        typed_resp.granted = directed_rows[i].granted;
        issue_request(directed_rows[i].knd, directed_rows[i].len, directed_rows[i].addr,
                      directed_rows[i].typed, typed_resp);
      end
    end
    wait_idle();
    live_runs.delete();

    bases[0] = '0;
    bases[1] = 12'($urandom_range(2, 4094));
    bases[2] = 12'd1;
    bases[3] = 12'd3968;
    bases[4] = 12'd4095;
    for (int p = 0; p < N_PHASES; p++) begin
      set_base(bases[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        no_idle = (n < 60);
        // The sender keeps offering while results are held back, so the input stalls.
        if (p == 1 && n == 0) hold_pending = 1'b1;
        random_request();
      end
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (ffra_pkg::FILE_ENTRIES + 8) @(posedge clk);
    $display("Ran %0d items over %0d base settings:", n_items, n_bases);
    $display("  %0d grants, %0d with no room, %0d rejected frees.",
             n_granted, n_no_room, n_bad_free);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ first_fit_register_run_allocator.f @@
rtl/ffra_pkg.sv
rtl/ffra_cell.sv
rtl/ffra_ctrl.sv
rtl/first_fit_register_run_allocator.sv
rtl/ffra_checker.sv
verif/tb_first_fit_register_run_allocator.sv
